### sv/ltok_pkg.sv
// ----------------------------------------------------------------------------
// ltok_pkg: shared types and constants of the lambda calculus tokeniser
// Token and queue record types, scan modes, token kinds, byte classes and
// the byte classifier used by the front end.
// ----------------------------------------------------------------------------
package ltok_pkg;

  localparam int LINE_W  = 16;
  localparam int VALUE_W = 31;
  localparam int CHAR_W  = 8;
  localparam int LEN_W   = 8;
  localparam int KIND_W  = 4;
  localparam int MAC_W   = VALUE_W + 4;

  localparam logic [VALUE_W-1:0] VALUE_MAX = '1;
  localparam logic [LEN_W-1:0]   LEN_MAX   = '1;
  localparam logic [LINE_W-1:0]  LINE_MAX  = '1;
  localparam logic [LINE_W-1:0]  LINE_RESET = 16'd1;

  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
  localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

  localparam int TOK_DATA_W = VALUE_W + 1 + CHAR_W + 1 + LEN_W + LINE_W;
  localparam int OUT_DATA_W = ((TOK_DATA_W + 7) / 8) * 8;

  localparam logic [CHAR_W-1:0] CH_TAB       = 8'h09;
  localparam logic [CHAR_W-1:0] CH_NEWLINE   = 8'h0A;
  localparam logic [CHAR_W-1:0] CH_SPACE     = 8'h20;
  localparam logic [CHAR_W-1:0] CH_DOLLAR    = 8'h24;
  localparam logic [CHAR_W-1:0] CH_OPEN      = 8'h28;
  localparam logic [CHAR_W-1:0] CH_CLOSE     = 8'h29;
  localparam logic [CHAR_W-1:0] CH_DOT       = 8'h2E;
  localparam logic [CHAR_W-1:0] CH_SLASH     = 8'h2F;
  localparam logic [CHAR_W-1:0] CH_ZERO      = 8'h30;
  localparam logic [CHAR_W-1:0] CH_NINE      = 8'h39;
  localparam logic [CHAR_W-1:0] CH_EQUAL     = 8'h3D;
  localparam logic [CHAR_W-1:0] CH_BACKSLASH = 8'h5C;
  localparam logic [CHAR_W-1:0] CH_UPPER_A   = 8'h41;
  localparam logic [CHAR_W-1:0] CH_UPPER_Z   = 8'h5A;
  localparam logic [CHAR_W-1:0] CH_LOWER_A   = 8'h61;
  localparam logic [CHAR_W-1:0] CH_LOWER_Z   = 8'h7A;
  localparam logic [CHAR_W-1:0] CH_LAMBDA_LEAD  = 8'hCE;
  localparam logic [CHAR_W-1:0] CH_LAMBDA_TRAIL = 8'hBB;

  typedef enum logic [2:0] {
    MODE_IDLE,
    MODE_NUMBER,
    MODE_IDENT,
    MODE_SLASH,
    MODE_COMMENT,
    MODE_LEAD,
    MODE_ERROR
  } mode_t;

  typedef enum logic [KIND_W-1:0] {
    KIND_LAMBDA      = 4'd0,
    KIND_DOT         = 4'd1,
    KIND_DOLLAR      = 4'd2,
    KIND_EQUAL       = 4'd3,
    KIND_OPEN        = 4'd4,
    KIND_CLOSE       = 4'd5,
    KIND_NUMBER      = 4'd6,
    KIND_IDCHAR      = 4'd7,
    KIND_IDEND       = 4'd8,
    KIND_EOT         = 4'd9,
    KIND_BAD_COMMENT = 4'd10,
    KIND_UNKNOWN     = 4'd11
  } kind_t;

  typedef enum logic [2:0] {
    CLS_BLANK,
    CLS_NEWLINE,
    CLS_SLASH,
    CLS_PUNCT,
    CLS_LEAD,
    CLS_DIGIT,
    CLS_LETTER,
    CLS_OTHER
  } class_t;

  typedef struct packed {
    class_t cls;
    kind_t  punct;
  } byte_info_t;

  typedef struct packed {
    kind_t               kind;
    logic [VALUE_W-1:0]  value;
    logic                ovf;
    logic [CHAR_W-1:0]   ch;
    logic                first;
    logic [LEN_W-1:0]    len;
    logic [LINE_W-1:0]   line;
  } token_t;

  // one queue record: every token caused by one input transaction
  typedef struct packed {
    logic   two;
    token_t tok0;
    token_t tok1;
  } pair_t;

  function automatic byte_info_t classify(input logic [CHAR_W-1:0] b);
    byte_info_t info;
    info.cls   = CLS_OTHER;
    info.punct = KIND_DOT;
    unique case (b)
      CH_SPACE, CH_TAB: info.cls = CLS_BLANK;
      CH_NEWLINE:       info.cls = CLS_NEWLINE;
      CH_SLASH:         info.cls = CLS_SLASH;
      CH_LAMBDA_LEAD:   info.cls = CLS_LEAD;
      CH_BACKSLASH: begin
        info.cls   = CLS_PUNCT;
        info.punct = KIND_LAMBDA;
      end
      CH_DOT: begin
        info.cls   = CLS_PUNCT;
        info.punct = KIND_DOT;
      end
      CH_DOLLAR: begin
        info.cls   = CLS_PUNCT;
        info.punct = KIND_DOLLAR;
      end
      CH_EQUAL: begin
        info.cls   = CLS_PUNCT;
        info.punct = KIND_EQUAL;
      end
      CH_OPEN: begin
        info.cls   = CLS_PUNCT;
        info.punct = KIND_OPEN;
      end
      CH_CLOSE: begin
        info.cls   = CLS_PUNCT;
        info.punct = KIND_CLOSE;
      end
      default: begin
        if (b >= CH_ZERO && b <= CH_NINE) begin
          info.cls = CLS_DIGIT;
        end else if ((b >= CH_UPPER_A && b <= CH_UPPER_Z) ||
                     (b >= CH_LOWER_A && b <= CH_LOWER_Z)) begin
          info.cls = CLS_LETTER;
        end
      end
    endcase
    return info;
  endfunction

  function automatic token_t plain_token(input kind_t k, input logic [LINE_W-1:0] line);
    token_t t;
    t       = '0;
    t.kind  = k;
    t.line  = line;
    return t;
  endfunction

endpackage

### sv/ltok_front.sv
// ----------------------------------------------------------------------------
// ltok_front: byte classifier and scanner
// Accepts one source transaction a cycle while the queue is not full, keeps
// the scan mode, number accumulator, identifier length and line count, and
// writes every token the transaction causes into the queue as one record.
// ----------------------------------------------------------------------------
module ltok_front (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_wen,
  input  logic [ltok_pkg::LINE_W-1:0]    cfg_wdata,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  input  logic [ltok_pkg::CHAR_W-1:0]    s_tdata,
  input  logic                           s_tuser,
  output logic                           push,
  output ltok_pkg::pair_t                push_data,
  input  logic                           full
);
  import ltok_pkg::*;

  mode_t               mode, mode_next;
  logic [VALUE_W-1:0]  acc, acc_next;
  logic                acc_ovf, acc_ovf_next;
  logic [LEN_W-1:0]    count, count_next;
  logic [LINE_W-1:0]   line, line_next;
  logic [LINE_W-1:0]   first_line;

  logic                accept;
  byte_info_t          info;
  logic                is_digit;
  logic                is_alnum;
  logic [LINE_W-1:0]   line_bumped;
  logic [LEN_W-1:0]    count_bumped;
  logic [VALUE_W-1:0]  digit_value;
  logic [MAC_W-1:0]    mac;
  logic                mac_sat;

  logic                idle_emit;
  token_t              idle_tok;
  logic                pre_emit;
  token_t              pre_tok;
  logic                tail_emit;
  token_t              tail_tok;

  assign s_tready     = !full;
  assign accept       = s_tvalid && s_tready;
  assign info         = classify(s_tdata);
  assign is_digit     = (info.cls == CLS_DIGIT);
  assign is_alnum     = is_digit || (info.cls == CLS_LETTER);
  assign line_bumped  = (line == LINE_MAX) ? line : line + 1'b1;
  assign count_bumped = (count == LEN_MAX) ? count : count + 1'b1;
  assign digit_value  = VALUE_W'(s_tdata[3:0]);
  assign mac          = {1'b0, acc, 3'b000} + {3'b000, acc, 1'b0} + MAC_W'(s_tdata[3:0]);
  assign mac_sat      = (mac > MAC_W'(VALUE_MAX));

  // next state
  always_comb begin
    mode_next    = mode;
    acc_next     = acc;
    acc_ovf_next = acc_ovf;
    count_next   = count;
    line_next    = line;
    if (accept) begin
      if (s_tuser) begin
        mode_next    = MODE_IDLE;
        acc_next     = '0;
        acc_ovf_next = 1'b0;
        count_next   = '0;
        line_next    = first_line;
      end else begin
        priority if (mode == MODE_ERROR) begin
          mode_next = MODE_ERROR;
        end else if (mode == MODE_COMMENT) begin
          if (info.cls == CLS_NEWLINE) begin
            line_next = line_bumped;
            mode_next = MODE_IDLE;
          end
        end else if (mode == MODE_SLASH) begin
          mode_next = (info.cls == CLS_SLASH) ? MODE_COMMENT : MODE_ERROR;
        end else if (mode == MODE_LEAD) begin
          mode_next = (s_tdata == CH_LAMBDA_TRAIL) ? MODE_IDLE : MODE_ERROR;
        end else if (mode == MODE_NUMBER && is_digit) begin
          acc_next     = mac_sat ? VALUE_MAX : mac[VALUE_W-1:0];
          acc_ovf_next = acc_ovf || mac_sat;
        end else if (mode == MODE_IDENT && is_alnum) begin
          count_next = count_bumped;
        end else begin
          // idle handling, also for the byte that ends a number or identifier
          unique case (info.cls)
            CLS_NEWLINE: begin
              line_next = line_bumped;
              mode_next = MODE_IDLE;
            end
            CLS_SLASH: mode_next = MODE_SLASH;
            CLS_LEAD:  mode_next = MODE_LEAD;
            CLS_DIGIT: begin
              mode_next    = MODE_NUMBER;
              acc_next     = digit_value;
              acc_ovf_next = 1'b0;
            end
            CLS_LETTER: begin
              mode_next  = MODE_IDENT;
              count_next = LEN_W'(1);
            end
            CLS_OTHER: mode_next = MODE_ERROR;
            default:   mode_next = MODE_IDLE;
          endcase
        end
      end
    end
  end

  // tokens
  always_comb begin
    idle_emit = 1'b0;
    idle_tok  = plain_token(info.punct, line);
    unique case (info.cls)
      CLS_PUNCT: idle_emit = 1'b1;
      CLS_LETTER: begin
        idle_emit      = 1'b1;
        idle_tok.kind  = KIND_IDCHAR;
        idle_tok.ch    = s_tdata;
        idle_tok.first = 1'b1;
      end
      CLS_OTHER: begin
        idle_emit     = 1'b1;
        idle_tok.kind = KIND_UNKNOWN;
        idle_tok.ch   = s_tdata;
      end
      default: idle_emit = 1'b0;
    endcase

    pre_emit  = 1'b0;
    pre_tok   = plain_token(KIND_NUMBER, line);
    tail_emit = 1'b0;
    tail_tok  = plain_token(KIND_EOT, line);

    if (s_tuser) begin
      tail_emit = 1'b1;
      unique case (mode)
        MODE_NUMBER: begin
          pre_emit      = 1'b1;
          pre_tok.value = acc;
          pre_tok.ovf   = acc_ovf;
        end
        MODE_IDENT: begin
          pre_emit     = 1'b1;
          pre_tok.kind = KIND_IDEND;
          pre_tok.len  = count;
        end
        MODE_SLASH: begin
          pre_emit     = 1'b1;
          pre_tok.kind = KIND_BAD_COMMENT;
        end
        MODE_LEAD: begin
          pre_emit     = 1'b1;
          pre_tok.kind = KIND_UNKNOWN;
          pre_tok.ch   = CH_LAMBDA_LEAD;
        end
        default: pre_emit = 1'b0;
      endcase
    end else begin
      unique case (mode)
        MODE_SLASH: begin
          tail_emit     = (info.cls != CLS_SLASH);
          tail_tok.kind = KIND_BAD_COMMENT;
        end
        MODE_LEAD: begin
          tail_emit = 1'b1;
          if (s_tdata == CH_LAMBDA_TRAIL) begin
            tail_tok.kind = KIND_LAMBDA;
          end else begin
            tail_tok.kind = KIND_UNKNOWN;
            tail_tok.ch   = CH_LAMBDA_LEAD;
          end
        end
        MODE_NUMBER: begin
          if (!is_digit) begin
            pre_emit      = 1'b1;
            pre_tok.value = acc;
            pre_tok.ovf   = acc_ovf;
            tail_emit     = idle_emit;
            tail_tok      = idle_tok;
          end
        end
        MODE_IDENT: begin
          if (is_alnum) begin
            tail_emit     = 1'b1;
            tail_tok      = idle_tok;
            tail_tok.kind = KIND_IDCHAR;
            tail_tok.ch   = s_tdata;
            tail_tok.first = 1'b0;
          end else begin
            pre_emit     = 1'b1;
            pre_tok.kind = KIND_IDEND;
            pre_tok.len  = count;
            tail_emit    = idle_emit;
            tail_tok     = idle_tok;
          end
        end
        MODE_IDLE: begin
          tail_emit = idle_emit;
          tail_tok  = idle_tok;
        end
        default: tail_emit = 1'b0;
      endcase
    end
  end

  assign push           = accept && (pre_emit || tail_emit);
  assign push_data.two  = pre_emit && tail_emit;
  assign push_data.tok0 = pre_emit ? pre_tok : tail_tok;
  assign push_data.tok1 = tail_tok;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode       <= MODE_IDLE;
      line       <= LINE_RESET;
      first_line <= LINE_RESET;
    end else begin
      mode <= mode_next;
      if (cfg_wen) begin
        first_line <= cfg_wdata;
        line       <= cfg_wdata;
      end else begin
        line <= line_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      acc     <= '0;
      acc_ovf <= 1'b0;
      count   <= '0;
    end else begin
      acc     <= acc_next;
      acc_ovf <= acc_ovf_next;
      count   <= count_next;
    end
  end

`ifndef SYNTH
  a_error_silent: assert property (@(posedge clk) disable iff (rst)
    (accept && !s_tuser && mode == MODE_ERROR) |-> !push)
    else $error("token produced while in error mode");

  a_eot_resets: assert property (@(posedge clk) disable iff (rst)
    (accept && s_tuser && !cfg_wen) |=> (mode == MODE_IDLE && line == first_line))
    else $error("end of text did not reset the scanner");

  a_eot_last: assert property (@(posedge clk) disable iff (rst)
    (accept && s_tuser) |-> (push && push_data.tok1.kind == KIND_EOT))
    else $error("end of text record missing its end mark");
`endif

endmodule

### sv/ltok_queue.sv
// ----------------------------------------------------------------------------
// ltok_queue: record queue between scanner and output stage
// Small register queue of token records, one write and one read a cycle.
// ----------------------------------------------------------------------------
module ltok_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  ltok_pkg::pair_t push_data,
  output logic            full,
  input  logic            pop,
  output ltok_pkg::pair_t pop_data,
  output logic            empty
);
  import ltok_pkg::*;

  pair_t                   entries [QUEUE_DEPTH];
  logic [QUEUE_PTR_W-1:0]  wr_ptr;
  logic [QUEUE_PTR_W-1:0]  rd_ptr;
  logic [QUEUE_CNT_W-1:0]  count;

  assign full     = (count == QUEUE_CNT_W'(QUEUE_DEPTH));
  assign empty    = (count == '0);
  assign pop_data = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

`ifndef SYNTH
  a_no_overrun: assert property (@(posedge clk) disable iff (rst) full |-> !push)
    else $error("write into a full queue");

  a_no_underrun: assert property (@(posedge clk) disable iff (rst) empty |-> !pop)
    else $error("read from an empty queue");
`endif

endmodule

### sv/ltok_back.sv
// ----------------------------------------------------------------------------
// ltok_back: token output stage
// Takes records from the queue and issues their tokens one per transaction
// through a registered output, marking the final token of each record.
// ----------------------------------------------------------------------------
module ltok_back (
  input  logic                              clk,
  input  logic                              rst,
  input  ltok_pkg::pair_t                   pop_data,
  input  logic                              empty,
  output logic                              pop,
  output logic                              m_tvalid,
  input  logic                              m_tready,
  output logic [ltok_pkg::OUT_DATA_W-1:0]   m_tdata,
  output logic [ltok_pkg::KIND_W-1:0]       m_tuser,
  output logic                              m_tlast
);
  import ltok_pkg::*;

  logic    sel;
  logic    load;
  logic    last_of_pair;
  token_t  head_tok;
  token_t  out_tok;

  assign load         = !empty && (!m_tvalid || m_tready);
  assign last_of_pair = !(pop_data.two && !sel);
  assign head_tok     = sel ? pop_data.tok1 : pop_data.tok0;
  assign pop          = load && last_of_pair;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
      sel      <= 1'b0;
    end else begin
      if (load) begin
        m_tvalid <= 1'b1;
        sel      <= !last_of_pair;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_tok <= head_tok;
      m_tlast <= last_of_pair;
    end
  end

  assign m_tuser = out_tok.kind;
  assign m_tdata = {{(OUT_DATA_W - TOK_DATA_W){1'b0}}, out_tok.line, out_tok.len,
                    out_tok.first, out_tok.ch, out_tok.ovf, out_tok.value};

`ifndef SYNTH
  a_second_held: assert property (@(posedge clk) disable iff (rst) sel |-> !empty)
    else $error("second token pending without its record");

  a_second_follows: assert property (@(posedge clk) disable iff (rst)
    (load && !last_of_pair) |=> (sel && !m_tlast))
    else $error("first token of a pair not followed by the second");
`endif

endmodule

### sv/lambda_calculus_tokenizer.sv
// ----------------------------------------------------------------------------
// lambda_calculus_tokenizer: streaming lexer for a small lambda calculus
// Source bytes enter on the s_ group; tokens leave on the m_ group.
//
// s_tuser is the opcode (0 source byte, 1 end of text), s_tdata the byte.
// m_tuser is the token kind, m_tlast marks the final token caused by one
// input transaction (an input causes zero, one or two tokens).
// cfg_wen/cfg_wdata write the first line number; the write also reloads the
// current line count. Write it only while the block is idle.
// A token passes through the record queue and the output register before it
// is presented on m_tvalid. Throughput: one input transaction per cycle while
// the queue is not full; the output issues one token per cycle while the
// receiver is ready, so an input causing two tokens takes two transfers. The
// scanner and the output stage are parted by a four-record queue, and s_tready
// drops only when that queue is full, so a stalled receiver backs up into the
// queue first.
// Reset: rst, synchronous; scanner idle, line number register back to 1,
// queue and output register empty.
// ----------------------------------------------------------------------------
module lambda_calculus_tokenizer (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_wen,
  input  logic [ltok_pkg::LINE_W-1:0]       cfg_wdata,
  input  logic                              s_tvalid,
  output logic                              s_tready,
  // source_byte [7:0]
  input  logic [ltok_pkg::CHAR_W-1:0]       s_tdata,
  // opcode [0]
  input  logic                              s_tuser,
  output logic                              m_tvalid,
  input  logic                              m_tready,
  // number_value [30:0], number_overflow [31], ident_char [39:32],
  // ident_first [40], ident_length [48:41], line_number [64:49], zero fill
  output logic [ltok_pkg::OUT_DATA_W-1:0]   m_tdata,
  // token_kind [3:0]
  output logic [ltok_pkg::KIND_W-1:0]       m_tuser,
  output logic                              m_tlast
);
  import ltok_pkg::*;

  logic   push;
  pair_t  push_data;
  logic   full;
  logic   pop;
  pair_t  pop_data;
  logic   empty;

  ltok_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_wen   (cfg_wen),
    .cfg_wdata (cfg_wdata),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .push      (push),
    .push_data (push_data),
    .full      (full)
  );

  ltok_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .full      (full),
    .pop       (pop),
    .pop_data  (pop_data),
    .empty     (empty)
  );

  ltok_back u_back (
    .clk      (clk),
    .rst      (rst),
    .pop_data (pop_data),
    .empty    (empty),
    .pop      (pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

endmodule

### tb/token_stream_checker.sv
// ----------------------------------------------------------------------------
// token_stream_checker: scoreboard for the lambda calculus tokeniser
// Watches the source byte stream, the token stream and the line number
// register writes. Every accepted source transaction is run through a
// behavioural lexer to get the tokens it must cause; every accepted token
// transaction is checked field by field against the oldest one waiting.
// ----------------------------------------------------------------------------
module token_stream_checker
  import ltok_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_wen,
  input  logic [LINE_W-1:0]     cfg_wdata,
  input  logic                  s_tvalid,
  input  logic                  s_tready,
  input  logic [CHAR_W-1:0]     s_tdata,
  input  logic                  s_tuser,
  input  logic                  m_tvalid,
  input  logic                  m_tready,
  input  logic [OUT_DATA_W-1:0] m_tdata,
  input  logic [KIND_W-1:0]     m_tuser,
  input  logic                  m_tlast,
  output int                    tokens_waiting,
  output int                    fault_total,
  output int                    tokens_checked
);

  typedef struct packed {
    logic [OUT_DATA_W-TOK_DATA_W-1:0] fill;
    logic [LINE_W-1:0]                line;
    logic [LEN_W-1:0]                 len;
    logic                             first;
    logic [CHAR_W-1:0]                ch;
    logic                             ovf;
    logic [VALUE_W-1:0]               value;
  } token_fields_t;

  typedef struct packed {
    kind_t              kind;
    logic [VALUE_W-1:0] value;
    logic               ovf;
    logic [CHAR_W-1:0]  ch;
    logic               first;
    logic [LEN_W-1:0]   len;
    logic [LINE_W-1:0]  line;
    logic               last;
  } lexed_token_t;

  lexed_token_t       pending_tokens[$];
  lexed_token_t       step_tokens[$];
  lexed_token_t       oldest;
  token_fields_t      seen;

  mode_t              lex_mode;
  logic [VALUE_W-1:0] num_acc;
  logic               num_ovf;
  logic [LEN_W-1:0]   id_len;
  logic [LINE_W-1:0]  line_base;
  logic [LINE_W-1:0]  line_now;
  int                 faults;
  int                 checked;

  function automatic logic is_decimal(input logic [CHAR_W-1:0] b);
    return b >= CH_ZERO && b <= CH_NINE;
  endfunction

  function automatic logic is_alpha(input logic [CHAR_W-1:0] b);
    return (b >= CH_UPPER_A && b <= CH_UPPER_Z) || (b >= CH_LOWER_A && b <= CH_LOWER_Z);
  endfunction

  task automatic emit(input kind_t k, input logic [VALUE_W-1:0] v, input logic o,
                      input logic [CHAR_W-1:0] c, input logic f, input logic [LEN_W-1:0] n);
    lexed_token_t t;
    t.kind  = k;
    t.value = v;
    t.ovf   = o;
    t.ch    = c;
    t.first = f;
    t.len   = n;
    t.line  = line_now;
    t.last  = 1'b0;
    step_tokens.insert(step_tokens.size(), t);
  endtask

  task automatic next_line();
    if (line_now != LINE_MAX) line_now = line_now + 1'b1;
  endtask

  task automatic restart_lexer();
    lex_mode = MODE_IDLE;
    num_acc  = '0;
    num_ovf  = 1'b0;
    id_len   = '0;
    line_now = line_base;
  endtask

  task automatic lex_from_idle(input logic [CHAR_W-1:0] b);
    lex_mode = MODE_IDLE;
    case (b)
      CH_SPACE, CH_TAB: ;
      CH_NEWLINE:     next_line();
      CH_SLASH:       lex_mode = MODE_SLASH;
      CH_LAMBDA_LEAD: lex_mode = MODE_LEAD;
      CH_BACKSLASH:   emit(KIND_LAMBDA, '0, 1'b0, '0, 1'b0, '0);
      CH_DOT:         emit(KIND_DOT, '0, 1'b0, '0, 1'b0, '0);
      CH_DOLLAR:      emit(KIND_DOLLAR, '0, 1'b0, '0, 1'b0, '0);
      CH_EQUAL:       emit(KIND_EQUAL, '0, 1'b0, '0, 1'b0, '0);
      CH_OPEN:        emit(KIND_OPEN, '0, 1'b0, '0, 1'b0, '0);
      CH_CLOSE:       emit(KIND_CLOSE, '0, 1'b0, '0, 1'b0, '0);
      default: begin
        if (is_decimal(b)) begin
          lex_mode = MODE_NUMBER;
          num_acc  = VALUE_W'(b - CH_ZERO);
          num_ovf  = 1'b0;
        end else if (is_alpha(b)) begin
          lex_mode = MODE_IDENT;
          id_len   = LEN_W'(1);
          emit(KIND_IDCHAR, '0, 1'b0, b, 1'b1, '0);
        end else begin
          lex_mode = MODE_ERROR;
          emit(KIND_UNKNOWN, '0, 1'b0, b, 1'b0, '0);
        end
      end
    endcase
  endtask

  // tokens caused by one source transaction, appended to pending_tokens
  task automatic lex_item(input logic end_of_text, input logic [CHAR_W-1:0] b);
    logic [MAC_W-1:0] wide;
    step_tokens.delete();
    if (end_of_text) begin
      case (lex_mode)
        MODE_NUMBER: emit(KIND_NUMBER, num_acc, num_ovf, '0, 1'b0, '0);
        MODE_IDENT:  emit(KIND_IDEND, '0, 1'b0, '0, 1'b0, id_len);
        MODE_SLASH:  emit(KIND_BAD_COMMENT, '0, 1'b0, '0, 1'b0, '0);
        MODE_LEAD:   emit(KIND_UNKNOWN, '0, 1'b0, CH_LAMBDA_LEAD, 1'b0, '0);
        default: ;
      endcase
      emit(KIND_EOT, '0, 1'b0, '0, 1'b0, '0);
      restart_lexer();
    end else begin
      case (lex_mode)
        MODE_ERROR: ;
        MODE_COMMENT: begin
          if (b == CH_NEWLINE) begin
            next_line();
            lex_mode = MODE_IDLE;
          end
        end
        MODE_SLASH: begin
          if (b == CH_SLASH) begin
            lex_mode = MODE_COMMENT;
          end else begin
            lex_mode = MODE_ERROR;
            emit(KIND_BAD_COMMENT, '0, 1'b0, '0, 1'b0, '0);
          end
        end
        MODE_LEAD: begin
          if (b == CH_LAMBDA_TRAIL) begin
            lex_mode = MODE_IDLE;
            emit(KIND_LAMBDA, '0, 1'b0, '0, 1'b0, '0);
          end else begin
            lex_mode = MODE_ERROR;
            emit(KIND_UNKNOWN, '0, 1'b0, CH_LAMBDA_LEAD, 1'b0, '0);
          end
        end
        MODE_NUMBER: begin
          if (is_decimal(b)) begin
            wide = MAC_W'(num_acc) * 10 + MAC_W'(b - CH_ZERO);
            if (wide > MAC_W'(VALUE_MAX)) begin
              num_acc = VALUE_MAX;
              num_ovf = 1'b1;
            end else begin
              num_acc = wide[VALUE_W-1:0];
            end
          end else begin
            emit(KIND_NUMBER, num_acc, num_ovf, '0, 1'b0, '0);
            lex_from_idle(b);
          end
        end
        MODE_IDENT: begin
          if (is_alpha(b) || is_decimal(b)) begin
            if (id_len != LEN_MAX) id_len = id_len + 1'b1;
            emit(KIND_IDCHAR, '0, 1'b0, b, 1'b0, '0);
          end else begin
            emit(KIND_IDEND, '0, 1'b0, '0, 1'b0, id_len);
            lex_from_idle(b);
          end
        end
        default: lex_from_idle(b);
      endcase
    end
    if (step_tokens.size() > 0) step_tokens[step_tokens.size()-1].last = 1'b1;
    foreach (step_tokens[i]) pending_tokens.insert(pending_tokens.size(), step_tokens[i]);
  endtask

  task automatic check_field(input string name, input longint unsigned want,
                             input longint unsigned got);
    if (want != got) begin
      $error("%s mismatch: expected %0d, got %0d", name, want, got);
      faults++;
    end
  endtask

  initial begin
    faults    = 0;
    checked   = 0;
    line_base = LINE_RESET;
    restart_lexer();
  end

  always @(posedge clk) begin
    if (rst) begin
      line_base = LINE_RESET;
      restart_lexer();
      pending_tokens.delete();
    end else begin
      if (cfg_wen) begin
        line_base = cfg_wdata;
        line_now  = cfg_wdata;
      end
      if (m_tvalid && m_tready) begin
        if (pending_tokens.size() == 0) begin
          $error("token of kind %0d with no expectation waiting", m_tuser);
          faults++;
        end else begin
          oldest = pending_tokens.pop_front();
          seen   = token_fields_t'(m_tdata);
          check_field("token_kind", oldest.kind, m_tuser);
          check_field("number_value", oldest.value, seen.value);
          check_field("number_overflow", oldest.ovf, seen.ovf);
          check_field("ident_char", oldest.ch, seen.ch);
          check_field("ident_first", oldest.first, seen.first);
          check_field("ident_length", oldest.len, seen.len);
          check_field("line_number", oldest.line, seen.line);
          check_field("last_of_run", oldest.last, m_tlast);
          check_field("zero_fill", 0, seen.fill);
          checked++;
        end
      end
      if (s_tvalid && s_tready) lex_item(s_tuser, s_tdata);
    end
    tokens_waiting <= pending_tokens.size();
    fault_total    <= faults;
    tokens_checked <= checked;
  end

endmodule

### tb/tb_lambda_calculus_tokenizer.sv
// ----------------------------------------------------------------------------
// tb_lambda_calculus_tokenizer: testbench top of the lambda calculus tokeniser
// Drives a short directed text covering every token and error path, then
// random lambda-calculus programs with noise and broken sequences over four
// idling phases and several first line numbers, including a long receiver
// hold-off. Checking is done by token_stream_checker.
// ----------------------------------------------------------------------------
module tb_lambda_calculus_tokenizer;
  import ltok_pkg::*;

  localparam logic OP_BYTE = 1'b0;
  localparam logic OP_EOT  = 1'b1;

  localparam int RESET_CYCLES  = 12;
  localparam int PHASE_ITEMS   = 420;
  localparam int SETTLE_CYCLES = 8;
  localparam int HOLD_CYCLES   = 300;
  localparam int PRESSURE_LEN  = 40;
  localparam int CYCLE_LIMIT   = 500000;

  logic                  clk       = 1'b0;
  logic                  rst       = 1'b1;
  logic                  cfg_wen   = 1'b0;
  logic [LINE_W-1:0]     cfg_wdata = '0;
  logic                  s_tvalid  = 1'b0;
  logic                  s_tready;
  logic [CHAR_W-1:0]     s_tdata   = '0;
  logic                  s_tuser   = OP_BYTE;
  logic                  m_tvalid;
  logic                  m_tready  = 1'b0;
  logic [OUT_DATA_W-1:0] m_tdata;
  logic [KIND_W-1:0]     m_tuser;
  logic                  m_tlast;

  int tokens_waiting;
  int fault_total;
  int tokens_checked;

  int   send_idle_pct  = 0;
  int   recv_stall_pct = 0;
  logic hold_req       = 1'b0;
  int   hold_left      = 0;
  int   cycle_count    = 0;
  int   items_sent     = 0;
  int   items_counted  = 0;
  int   programs_sent  = 0;

  logic [CHAR_W-1:0] punct_bytes[6] = '{CH_BACKSLASH, CH_DOT, CH_DOLLAR,
                                        CH_EQUAL, CH_OPEN, CH_CLOSE};
  logic [CHAR_W-1:0] blank_bytes[3] = '{CH_SPACE, CH_TAB, CH_NEWLINE};
  logic [LINE_W-1:0] phase_base[4];

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  lambda_calculus_tokenizer i_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_wen   (cfg_wen),
    .cfg_wdata (cfg_wdata),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .m_tlast   (m_tlast)
  );

  token_stream_checker i_checker (
    .clk            (clk),
    .rst            (rst),
    .cfg_wen        (cfg_wen),
    .cfg_wdata      (cfg_wdata),
    .s_tvalid       (s_tvalid),
    .s_tready       (s_tready),
    .s_tdata        (s_tdata),
    .s_tuser        (s_tuser),
    .m_tvalid       (m_tvalid),
    .m_tready       (m_tready),
    .m_tdata        (m_tdata),
    .m_tuser        (m_tuser),
    .m_tlast        (m_tlast),
    .tokens_waiting (tokens_waiting),
    .fault_total    (fault_total),
    .tokens_checked (tokens_checked)
  );

  // receiver: random stalls, or a long hold-off when requested
  always @(posedge clk) begin
    if (hold_req) begin
      hold_left <= HOLD_CYCLES;
      m_tready  <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      m_tready  <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("cycle limit reached with %0d tokens outstanding", tokens_waiting);
      $display("TEST FAILED");
      $finish;
    end
  end

  task automatic send_item(input logic op, input logic [CHAR_W-1:0] b);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= op;
    s_tdata  <= b;
    do @(posedge clk); while (!s_tready);
    items_sent++;
    items_counted++;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_item(OP_BYTE, s[i]);
  endtask

  task automatic end_text();
    send_item(OP_EOT, CHAR_W'($urandom));
  endtask

  // sender pause until every expected token has arrived
  task automatic drain();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (tokens_waiting != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_line_base(input logic [LINE_W-1:0] v);
    drain();
    cfg_wen   <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_wen   <= 1'b0;
  endtask

  function automatic logic [CHAR_W-1:0] pick_letter();
    if ($urandom_range(1)) return CHAR_W'($urandom_range(CH_LOWER_A, CH_LOWER_Z));
    return CHAR_W'($urandom_range(CH_UPPER_A, CH_UPPER_Z));
  endfunction

  function automatic logic [CHAR_W-1:0] pick_digit();
    return CHAR_W'($urandom_range(CH_ZERO, CH_NINE));
  endfunction

  task automatic send_identifier(input int len);
    send_item(OP_BYTE, pick_letter());
    for (int i = 1; i < len; i++)
      send_item(OP_BYTE, $urandom_range(2) == 0 ? pick_digit() : pick_letter());
  endtask

  task automatic send_fragment();
    int                pick;
    int                len;
    logic [CHAR_W-1:0] b;
    pick = $urandom_range(99);
    if (pick < 12) begin
      send_item(OP_BYTE, punct_bytes[$urandom_range(5)]);
    end else if (pick < 18) begin
      send_item(OP_BYTE, CH_LAMBDA_LEAD);
      send_item(OP_BYTE, CH_LAMBDA_TRAIL);
    end else if (pick < 38) begin
      len = ($urandom_range(99) < 15) ? $urandom_range(9, 12) : $urandom_range(1, 4);
      repeat (len) send_item(OP_BYTE, pick_digit());
    end else if (pick < 63) begin
      len = ($urandom_range(199) == 0) ? $urandom_range(250, 262) : $urandom_range(1, 8);
      send_identifier(len);
    end else if (pick < 78) begin
      send_item(OP_BYTE, blank_bytes[$urandom_range(2)]);
    end else if (pick < 84) begin
      send_item(OP_BYTE, CH_SLASH);
      send_item(OP_BYTE, CH_SLASH);
      repeat ($urandom_range(0, 6)) begin
        do b = CHAR_W'($urandom); while (b == CH_NEWLINE);
        send_item(OP_BYTE, b);
      end
      send_item(OP_BYTE, CH_NEWLINE);
    end else if (pick < 92) begin
      send_item(OP_BYTE, CHAR_W'($urandom));
    end else if ($urandom_range(1)) begin
      send_item(OP_BYTE, CH_SLASH);
      do b = CHAR_W'($urandom); while (b == CH_SLASH);
      send_item(OP_BYTE, b);
    end else begin
      send_item(OP_BYTE, CH_LAMBDA_LEAD);
      do b = CHAR_W'($urandom); while (b == CH_LAMBDA_TRAIL);
      send_item(OP_BYTE, b);
    end
  endtask

  // a run of fragments closed by end of text, now and then with a dangling
  // slash or lambda lead byte for the flush
  task automatic send_program();
    int tail;
    repeat ($urandom_range(3, 25)) send_fragment();
    tail = $urandom_range(19);
    if (tail == 0) send_item(OP_BYTE, CH_SLASH);
    else if (tail == 1) send_item(OP_BYTE, CH_LAMBDA_LEAD);
    end_text();
    programs_sent++;
  endtask

  initial begin
    phase_base[0] = '0;
    phase_base[1] = LINE_MAX - 1'b1;
    phase_base[2] = LINE_W'($urandom_range(0, LINE_MAX));
    phase_base[3] = LINE_MAX;

    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed text with the reset line number
    send_text("\\.$=()");
    send_item(OP_BYTE, CH_LAMBDA_LEAD);
    send_item(OP_BYTE, CH_LAMBDA_TRAIL);
    send_text("7aZ9\t");
    send_text("//\n0");
    end_text();
    send_text("q");
    end_text();
    send_item(OP_BYTE, CH_SLASH);
    end_text();
    send_item(OP_BYTE, CH_LAMBDA_LEAD);
    end_text();
    send_text("/x");
    send_item(OP_BYTE, 8'hFF);
    end_text();
    send_item(OP_BYTE, CH_LAMBDA_LEAD);
    send_item(OP_BYTE, 8'h00);
    end_text();
    send_item(OP_BYTE, CH_LAMBDA_TRAIL);
    end_text();

    for (int phase = 0; phase < 4; phase++) begin
      write_line_base(phase_base[phase]);
      case (phase)
        0: begin
          send_idle_pct  <= 0;
          recv_stall_pct <= 0;
        end
        1: begin
          send_idle_pct  <= 70;
          recv_stall_pct <= 0;
        end
        2: begin
          send_idle_pct  <= 0;
          recv_stall_pct <= 70;
        end
        default: begin
          send_idle_pct  <= 22;
          recv_stall_pct <= 22;
        end
      endcase
      if (phase == 0) begin
        // receiver held off while the sender keeps offering source bytes
        hold_req <= 1'b1;
        @(posedge clk);
        hold_req <= 1'b0;
        repeat (PRESSURE_LEN) send_item(OP_BYTE, punct_bytes[$urandom_range(5)]);
        end_text();
        drain();
        send_identifier(260);
        send_item(OP_BYTE, CH_NEWLINE);
        end_text();
      end
      items_counted = 0;
      while (items_counted < PHASE_ITEMS) send_program();
    end

    drain();
    $display("%0d source transactions in %0d random programs, %0d tokens checked",
             items_sent, programs_sent, tokens_checked);
    $display("four idling phases, first line numbers %0d %0d %0d %0d, one long hold-off",
             phase_base[0], phase_base[1], phase_base[2], phase_base[3]);
    if (fault_total == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
